>>> rtl/ilru_pkg.sv
package ilru_pkg;

	localparam int FIELD_W = 10;
	localparam int CMD_W   = 3;
	localparam int SLOTS   = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD_HEAD  = 3'd0,
		CMD_ADD_TAIL  = 3'd1,
		CMD_MOVE_HEAD = 3'd2,
		CMD_MOVE_TAIL = 3'd3,
		CMD_REMOVE    = 3'd4
	} cmd_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_EVAL  = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

>>> rtl/ilru_link_mem.sv
module ilru_link_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/ilru_plan.sv
module ilru_plan import ilru_pkg::*; #(
	parameter int AW = 10
) (
	input  logic [CMD_W-1:0]          cmd,
	input  logic                      bad,
	input  logic [AW-1:0]             e,
	input  logic [AW-1:0]             p,
	input  logic [AW-1:0]             n,
	input  logic [AW-1:0]             head,
	input  logic [AW-1:0]             tail,
	output logic                      applied,
	output logic [SLOTS-1:0]          pv_en,
	output logic [SLOTS-1:0][AW-1:0]  pv_addr,
	output logic [SLOTS-1:0][AW-1:0]  pv_data,
	output logic [SLOTS-1:0]          nx_en,
	output logic [SLOTS-1:0][AW-1:0]  nx_addr,
	output logic [SLOTS-1:0][AW-1:0]  nx_data
);

	logic unlinked;
	logic linked;
	logic [AW-1:0] root;

	assign root     = '0;
	assign unlinked = (p == e) && (n == e);
	assign linked   = (p != e) && (n != e);

	always_comb begin
		applied = 1'b0;
		pv_en   = '0;
		pv_addr = '0;
		pv_data = '0;
		nx_en   = '0;
		nx_addr = '0;
		nx_data = '0;
		if (!bad) begin
			unique case (cmd)
				CMD_ADD_HEAD: begin
					if (unlinked) begin
						applied = 1'b1;
						pv_en = 3'b011;
						pv_addr[0] = head; pv_data[0] = e;
						pv_addr[1] = e;    pv_data[1] = root;
						nx_en = 3'b011;
						nx_addr[0] = e;    nx_data[0] = head;
						nx_addr[1] = root; nx_data[1] = e;
					end
				end
				CMD_ADD_TAIL: begin
					if (unlinked) begin
						applied = 1'b1;
						pv_en = 3'b011;
						pv_addr[0] = root; pv_data[0] = e;
						pv_addr[1] = e;    pv_data[1] = tail;
						nx_en = 3'b011;
						nx_addr[0] = e;    nx_data[0] = root;
						nx_addr[1] = tail; nx_data[1] = e;
					end
				end
				CMD_MOVE_HEAD: begin
					if (linked && (p != root) && (p != n)) begin
						applied = 1'b1;
						pv_en = 3'b111;
						pv_addr[0] = n;    pv_data[0] = p;
						pv_addr[1] = head; pv_data[1] = e;
						pv_addr[2] = e;    pv_data[2] = root;
						nx_en = 3'b111;
						nx_addr[0] = p;    nx_data[0] = n;
						nx_addr[1] = e;    nx_data[1] = head;
						nx_addr[2] = root; nx_data[2] = e;
					end
				end
				CMD_MOVE_TAIL: begin
					if (linked && (n != root) && (p != n)) begin
						applied = 1'b1;
						pv_en = 3'b111;
						pv_addr[0] = n;    pv_data[0] = p;
						pv_addr[1] = root; pv_data[1] = e;
						pv_addr[2] = e;    pv_data[2] = tail;
						nx_en = 3'b111;
						nx_addr[0] = p;    nx_data[0] = n;
						nx_addr[1] = e;    nx_data[1] = root;
						nx_addr[2] = tail; nx_data[2] = e;
					end
				end
				CMD_REMOVE: begin
					if (linked) begin
						applied = 1'b1;
						pv_en = 3'b011;
						pv_addr[0] = n; pv_data[0] = p;
						pv_addr[1] = e; pv_data[1] = e;
						nx_en = 3'b011;
						nx_addr[0] = p; nx_data[0] = n;
						nx_addr[1] = e; nx_data[1] = e;
					end
				end
				default: begin
					applied = 1'b0;
				end
			endcase
		end
	end

endmodule

>>> rtl/indexed_lru_list_engine.sv
// Circular doubly linked recency list over POOL_ENTRIES entries; entry 0 is
// the root, whose next link is the head and whose previous link the tail.
// Request channel: in_valid/in_ready with cmd and entry_index. Result
// channel: out_valid/out_ready with applied, list_empty, head_entry and
// tail_entry, one result per request, in order.
// Steps: a request is taken while idle, its links are read from the prev
// and next link memories as it is taken, and up to three link writes per
// memory follow, one per cycle on the single write port of each memory.
// The result is then loaded into the output register once that register
// is free; a command that is not applied skips the link writes. The root
// links live in registers.
// Reset: a clearing pass writes each entry's own index into both
// memories; in_ready stays low until it ends.
// Stall: a waiting result sits in the output register while the next
// request is taken and worked; that request's result waits in its last
// step until the output register is free.
module indexed_lru_list_engine import ilru_pkg::*; #(
	parameter int POOL_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [FIELD_W-1:0] entry_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               applied,
	output logic               list_empty,
	output logic [FIELD_W-1:0] head_entry,
	output logic [FIELD_W-1:0] tail_entry
);

	localparam int AW = $clog2(POOL_ENTRIES);

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [1:0] slot_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CMD_W-1:0] cmd_q;
	logic [AW-1:0] e_q;
	logic bad_q;
	logic applied_q;
	logic [SLOTS-1:0] pv_en_q;
	logic [SLOTS-1:0][AW-1:0] pv_addr_q;
	logic [SLOTS-1:0][AW-1:0] pv_data_q;
	logic [SLOTS-1:0] nx_en_q;
	logic [SLOTS-1:0][AW-1:0] nx_addr_q;
	logic [SLOTS-1:0][AW-1:0] nx_data_q;
	logic out_valid_q;
	logic out_applied_q;
	logic out_empty_q;
	logic [AW-1:0] out_head_q;
	logic [AW-1:0] out_tail_q;

	logic accept;
	logic in_pool;
	logic [AW-1:0] e_addr;
	logic [AW-1:0] p_rd;
	logic [AW-1:0] n_rd;
	logic pl_applied;
	logic [SLOTS-1:0] pl_pv_en;
	logic [SLOTS-1:0][AW-1:0] pl_pv_addr;
	logic [SLOTS-1:0][AW-1:0] pl_pv_data;
	logic [SLOTS-1:0] pl_nx_en;
	logic [SLOTS-1:0][AW-1:0] pl_nx_addr;
	logic [SLOTS-1:0][AW-1:0] pl_nx_data;
	logic pv_we;
	logic [AW-1:0] pv_waddr;
	logic [AW-1:0] pv_wdata;
	logic nx_we;
	logic [AW-1:0] nx_waddr;
	logic [AW-1:0] nx_wdata;
	logic cur_pv_en;
	logic cur_nx_en;
	logic out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_pool  = (32'(entry_index) < POOL_ENTRIES);
	assign e_addr   = AW'(entry_index);
	assign out_free = !out_valid_q || out_ready;

	assign cur_pv_en = pv_en_q[slot_q];
	assign cur_nx_en = nx_en_q[slot_q];

	always_comb begin
		if (state_q == ST_CLEAR) begin
			pv_we    = 1'b1;
			pv_waddr = clr_q;
			pv_wdata = clr_q;
			nx_we    = 1'b1;
			nx_waddr = clr_q;
			nx_wdata = clr_q;
		end else begin
			pv_we    = (state_q == ST_WRITE) && cur_pv_en && (pv_addr_q[slot_q] != '0);
			pv_waddr = pv_addr_q[slot_q];
			pv_wdata = pv_data_q[slot_q];
			nx_we    = (state_q == ST_WRITE) && cur_nx_en && (nx_addr_q[slot_q] != '0);
			nx_waddr = nx_addr_q[slot_q];
			nx_wdata = nx_data_q[slot_q];
		end
	end

	ilru_link_mem #(.DEPTH(POOL_ENTRIES), .AW(AW)) u_prev_mem (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.raddr (e_addr),
		.rdata (p_rd)
	);

	ilru_link_mem #(.DEPTH(POOL_ENTRIES), .AW(AW)) u_next_mem (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (e_addr),
		.rdata (n_rd)
	);

	ilru_plan #(.AW(AW)) u_plan (
		.cmd     (cmd_q),
		.bad     (bad_q),
		.e       (e_q),
		.p       (p_rd),
		.n       (n_rd),
		.head    (head_q),
		.tail    (tail_q),
		.applied (pl_applied),
		.pv_en   (pl_pv_en),
		.pv_addr (pl_pv_addr),
		.pv_data (pl_pv_data),
		.nx_en   (pl_nx_en),
		.nx_addr (pl_nx_addr),
		.nx_data (pl_nx_data)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			e_q   <= e_addr;
			bad_q <= !in_pool || (entry_index == '0);
		end
		if (state_q == ST_EVAL) begin
			applied_q <= pl_applied;
			pv_en_q   <= pl_pv_en;
			pv_addr_q <= pl_pv_addr;
			pv_data_q <= pl_pv_data;
			nx_en_q   <= pl_nx_en;
			nx_addr_q <= pl_nx_addr;
			nx_data_q <= pl_nx_data;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_applied_q <= applied_q;
			out_empty_q   <= (head_q == '0);
			out_head_q    <= head_q;
			out_tail_q    <= tail_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			slot_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(POOL_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					slot_q <= '0;
					if (pl_applied) begin
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_WRITE: begin
					if (cur_pv_en && (pv_addr_q[slot_q] == '0)) begin
						tail_q <= pv_data_q[slot_q];
					end
					if (cur_nx_en && (nx_addr_q[slot_q] == '0)) begin
						head_q <= nx_data_q[slot_q];
					end
					slot_q <= slot_q + 1'b1;
					if (slot_q == 2'(SLOTS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign applied    = out_applied_q;
	assign list_empty = out_empty_q;
	assign head_entry = FIELD_W'(out_head_q);
	assign tail_entry = FIELD_W'(out_tail_q);

endmodule
